/* rtl/drive_motor_off_delay_timer_unit_assert.svh */
// ----------------------------------------------------------------------------
// drive motor off-delay timer assertion macros
// shared property shapes for the timer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DRIVE_MOTOR_OFF_DELAY_TIMER_UNIT_ASSERT_SVH
`define DRIVE_MOTOR_OFF_DELAY_TIMER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DMOT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmot implication check failed");

// expression must hold at every clock edge out of reset
`define DMOT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dmot invariant check failed");

`endif

/* rtl/dmot_pkg.sv */
// ----------------------------------------------------------------------------
// dmot_pkg
// types, codes and constants of the drive motor off-delay timer
// ----------------------------------------------------------------------------
package dmot_pkg;

    // number of drive motors served
    localparam int DRIVE_COUNT = 4;

    // fixed field widths
    localparam int DRIVE_W = 2;
    localparam int MASK_W  = 4;
    localparam int MS_W    = 16;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 1;

    // motor phase codes
    localparam logic [PHASE_W-1:0] PHASE_OFF  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ON   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd2;

    // word kinds
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH = 1'd1;

    // configuration reset values
    localparam logic [MS_W-1:0] OFF_DELAY_RESET   = 16'd2500;
    localparam logic [MS_W-1:0] TICK_LENGTH_RESET = 16'd400;

    typedef struct packed {
        logic               mode;
        logic [DRIVE_W-1:0] drive;
        logic               turn_on;
    } req_word_t;

    typedef struct packed {
        logic [MASK_W-1:0] motor_mask;
        logic              started;
        logic [MASK_W-1:0] stopped_mask;
    } res_word_t;

    // input stage to result stage handshake
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

/* rtl/drive_motor_off_delay_timer_unit.sv */
// ----------------------------------------------------------------------------
// drive_motor_off_delay_timer_unit
// off-delay timer for up to four drive motors with a motor-enable mask
// ----------------------------------------------------------------------------
//  channel  direction  flow control          word
//  req      in         req_valid / req_stall  mode, drive, turn_on
//  res      out        res_valid / res_stall  motor_mask, started, stopped_mask
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
//  one word in per cycle while req_stall is low, one result word out per word
//  a word passes the input register, the update logic and the result register
//  all four drive countdowns update in parallel when the held word advances
//  rst_n clears phases, countdowns, enable mask and loads the default delays
//  res_stall holds the result register and, once the input register is
//  also full, raises req_stall in the same cycle
// ----------------------------------------------------------------------------
module drive_motor_off_delay_timer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  dmot_pkg::req_word_t            req_word,
    output logic                           res_valid,
    input  logic                           res_stall,
    output dmot_pkg::res_word_t            res_word,
    input  logic                           cfg_we,
    input  logic [dmot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmot_pkg::MS_W-1:0]      cfg_data
);
    import dmot_pkg::*;

    // word waiting in the input register
    logic       stage_valid;
    req_word_t  stage_word;

    // advance control back from the result register
    stage_ctl_t ctl;

    // result of the update logic for the held word
    res_word_t  res_next;

    // input register, stalls only while the held word cannot advance
    dmot_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_word    (req_word),
        .advance     (ctl.advance),
        .stage_valid (stage_valid),
        .stage_word  (stage_word)
    );

    // motor state and configuration; state commits when the word advances
    dmot_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .word      (stage_word),
        .res_next  (res_next)
    );

    // result register, a word drained in the same cycle makes room for the next
    dmot_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .ctl         (ctl),
        .res_next    (res_next),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_word    (res_word)
    );

endmodule

/* rtl/dmot_in_stage.sv */
// ----------------------------------------------------------------------------
// dmot_in_stage
// input register holding one request or tick word for the update logic
// ----------------------------------------------------------------------------
module dmot_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  dmot_pkg::req_word_t req_word,
    input  logic                advance,
    output logic                stage_valid,
    output dmot_pkg::req_word_t stage_word
);
    import dmot_pkg::*;

    logic      valid_reg;
    req_word_t word_reg;

    // held word cannot move on
    assign req_stall   = valid_reg & ~advance;
    assign stage_valid = valid_reg;
    assign stage_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            word_reg <= req_word;
        end
    end

endmodule

/* rtl/dmot_core.sv */
// ----------------------------------------------------------------------------
// dmot_core
// per-drive phase and countdown state, configuration and next-state logic
// ----------------------------------------------------------------------------
`include "drive_motor_off_delay_timer_unit_assert.svh"

module dmot_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dmot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmot_pkg::MS_W-1:0]     cfg_data,
    input  dmot_pkg::stage_ctl_t          ctl,
    input  dmot_pkg::req_word_t           word,
    output dmot_pkg::res_word_t           res_next
);
    import dmot_pkg::*;

    logic [MS_W-1:0]    off_delay_reg;
    logic [MS_W-1:0]    tick_length_reg;
    logic [PHASE_W-1:0] phase_reg  [DRIVE_COUNT];
    logic [PHASE_W-1:0] phase_next [DRIVE_COUNT];
    logic [MS_W-1:0]    count_reg  [DRIVE_COUNT];
    logic [MS_W-1:0]    count_next [DRIVE_COUNT];
    logic [MASK_W-1:0]  enable_reg;
    logic [MASK_W-1:0]  enable_next;
    logic               started;
    logic [MASK_W-1:0]  stopped;
    logic [MASK_W-1:0]  live;
    logic               tick_taken;
    logic               request_taken;
    logic [MASK_W-1:0]  stop_overlap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_delay_reg   <= OFF_DELAY_RESET;
            tick_length_reg <= TICK_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFF_DELAY:   off_delay_reg   <= cfg_data;
                CFG_TICK_LENGTH: tick_length_reg <= cfg_data;
                default:         off_delay_reg   <= off_delay_reg;
            endcase
        end
    end

    always_comb
    begin
        enable_next = enable_reg;
        started     = 1'b0;
        stopped     = '0;
        for (int i = 0; i < DRIVE_COUNT; i++)
        begin
            phase_next[i] = phase_reg[i];
            count_next[i] = count_reg[i];
        end
        if (word.mode == MODE_REQUEST)
        begin
            for (int i = 0; i < DRIVE_COUNT; i++)
            begin
                if (word.drive == DRIVE_W'(i))
                begin
                    unique case (phase_reg[i])
                        PHASE_OFF:
                        begin
                            if (word.turn_on)
                            begin
                                enable_next[i] = 1'b1;
                                phase_next[i]  = PHASE_ON;
                                started        = 1'b1;
                            end
                        end
                        PHASE_ON:
                        begin
                            if (!word.turn_on)
                            begin
                                phase_next[i] = PHASE_WAIT;
                                count_next[i] = off_delay_reg;
                            end
                        end
                        PHASE_WAIT:
                        begin
                            if (word.turn_on)
                            begin
                                phase_next[i] = PHASE_ON;
                            end
                        end
                        default:
                        begin
                            phase_next[i] = phase_reg[i];
                        end
                    endcase
                end
            end
        end
        else
        begin
            for (int i = 0; i < DRIVE_COUNT; i++)
            begin
                if (phase_reg[i] == PHASE_WAIT)
                begin
                    if (count_reg[i] <= tick_length_reg)
                    begin
                        count_next[i]  = '0;
                        phase_next[i]  = PHASE_OFF;
                        enable_next[i] = 1'b0;
                        stopped[i]     = 1'b1;
                    end
                    else
                    begin
                        count_next[i] = count_reg[i] - tick_length_reg;
                    end
                end
            end
        end
        res_next.motor_mask   = enable_next;
        res_next.started      = started;
        res_next.stopped_mask = stopped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            for (int i = 0; i < DRIVE_COUNT; i++)
            begin
                phase_reg[i] <= PHASE_OFF;
                count_reg[i] <= '0;
            end
        end
        else if (ctl.advance)
        begin
            enable_reg <= enable_next;
            for (int i = 0; i < DRIVE_COUNT; i++)
            begin
                phase_reg[i] <= phase_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // motors that are spinning, for the checks below
    always_comb
    begin
        live = '0;
        for (int i = 0; i < DRIVE_COUNT; i++)
        begin
            live[i] = (phase_reg[i] != PHASE_OFF);
        end
    end

    assign tick_taken    = ctl.advance && (word.mode == MODE_TICK);
    assign request_taken = ctl.advance && (word.mode == MODE_REQUEST);
    assign stop_overlap  = res_next.motor_mask & res_next.stopped_mask;

    `DMOT_ASSERT_ALWAYS(a_enable_tracks_phase, clk, rst_n, enable_reg == live)
    `DMOT_ASSERT_IMPLY(a_advance_needs_valid, clk, rst_n, ctl.advance, ctl.valid)
    `DMOT_ASSERT_IMPLY(a_tick_never_starts, clk, rst_n, tick_taken, !res_next.started)
    `DMOT_ASSERT_IMPLY(a_request_never_stops, clk, rst_n, request_taken, stopped == '0)
    `DMOT_ASSERT_IMPLY(a_stopped_bits_cleared, clk, rst_n, ctl.advance, stop_overlap == '0)

endmodule

/* rtl/dmot_out_stage.sv */
// ----------------------------------------------------------------------------
// dmot_out_stage
// result register and advance control for the input stage
// ----------------------------------------------------------------------------
module dmot_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stage_valid,
    output dmot_pkg::stage_ctl_t ctl,
    input  dmot_pkg::res_word_t res_next,
    output logic                res_valid,
    input  logic                res_stall,
    output dmot_pkg::res_word_t res_word
);
    import dmot_pkg::*;

    logic      valid_reg;
    res_word_t word_reg;

    // held word moves on when the result register is free or drained now
    assign ctl.valid   = stage_valid;
    assign ctl.advance = stage_valid & (~valid_reg | ~res_stall);
    assign res_valid   = valid_reg;
    assign res_word    = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            word_reg <= res_next;
        end
    end

endmodule

/* test/drive_motor_off_delay_timer_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drive_motor_off_delay_timer_unit_test
// self-checking bench for the four-drive motor off-delay timer: a queue-fed
// driver sends request and tick words under random idling, a monitor checks
// every result word against a cycle-free model of the phases and countdowns
// ----------------------------------------------------------------------------
module drive_motor_off_delay_timer_unit_test;

    import dmot_pkg::*;

    // cycles without any accepted word before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_word_t            req_word = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_word_t            res_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OFF_DELAY;
    logic [MS_W-1:0]      cfg_data = '0;

    // words waiting to be driven, results waiting to be checked
    req_word_t pending_words[$];
    res_word_t expected_status[$];

    // percentage of cycles in which each side holds back
    int idle_pct = 29;
    int error_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // model state: phase and countdown per drive, the enable mask, the registers
    logic [PHASE_W-1:0] drive_phase [DRIVE_COUNT];
    logic [MS_W-1:0]    countdown_ms [DRIVE_COUNT];
    logic [MASK_W-1:0]  motors_on = '0;
    logic [MS_W-1:0]    off_delay_setting = OFF_DELAY_RESET;
    logic [MS_W-1:0]    tick_length_setting = TICK_LENGTH_RESET;

    res_word_t want;

    drive_motor_off_delay_timer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < DRIVE_COUNT; i++)
        begin
            drive_phase[i] = PHASE_OFF;
            countdown_ms[i] = '0;
        end
    end

    // advances the motor model by one word and returns the status it reports
    function automatic res_word_t motor_timer_step(req_word_t w);
        res_word_t r;
        int        d;
        int        i;
        r = '0;
        d = int'(w.drive);
        if (w.mode == MODE_REQUEST)
        begin
            // drive numbers past the fitted drives are ignored
            if (d < DRIVE_COUNT)
            begin
                if (w.turn_on)
                begin
                    if (drive_phase[d] == PHASE_OFF)
                    begin
                        motors_on[d] = 1'b1;
                        drive_phase[d] = PHASE_ON;
                        r.started = 1'b1;
                    end
                    else if (drive_phase[d] == PHASE_WAIT)
                    begin
                        // countdown stays where it was
                        drive_phase[d] = PHASE_ON;
                    end
                end
                else if (drive_phase[d] == PHASE_ON)
                begin
                    drive_phase[d] = PHASE_WAIT;
                    countdown_ms[d] = off_delay_setting;
                end
            end
        end
        else
        begin
            for (i = 0; i < DRIVE_COUNT; i++)
            begin
                if (drive_phase[i] == PHASE_WAIT)
                begin
                    // a countdown at or below one tick floors at zero and stops
                    if (countdown_ms[i] <= tick_length_setting)
                    begin
                        countdown_ms[i] = '0;
                        drive_phase[i] = PHASE_OFF;
                        motors_on[i] = 1'b0;
                        r.stopped_mask[i] = 1'b1;
                    end
                    else
                    begin
                        countdown_ms[i] = countdown_ms[i] - tick_length_setting;
                    end
                end
            end
        end
        r.motor_mask = motors_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch in %s at result word %0d: got %0h, expected %0h",
                 what, results_seen, got, exp_val);
        error_count++;
    endtask

    task automatic queue_request(input int drive, input bit on);
        req_word_t w;
        w.mode = MODE_REQUEST;
        w.drive = drive[DRIVE_W-1:0];
        w.turn_on = on;
        pending_words.push_back(w);
    endtask

    // drive and turn_on carry junk on a tick, the block must ignore them
    task automatic queue_tick();
        req_word_t w;
        w.mode = MODE_TICK;
        w.drive = DRIVE_W'($urandom);
        w.turn_on = 1'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic write_timer_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [MS_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OFF_DELAY)
            off_delay_setting = value;
        else
            tick_length_setting = value;
    endtask

    task automatic set_timer_config(input int off_delay, input int tick_length);
        write_timer_reg(CFG_OFF_DELAY, off_delay[MS_W-1:0]);
        write_timer_reg(CFG_TICK_LENGTH, tick_length[MS_W-1:0]);
    endtask

    // block until every queued word went in and every result came back
    task automatic wait_drained();
        while (pending_words.size() != 0 || req_valid || expected_status.size() != 0)
            @(posedge clk);
        // two-stage pipe, let it settle before the next phase
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase(input int off_delay, input int tick_length,
                                    input int tick_pct, input int idle, input int count);
        set_timer_config(off_delay, tick_length);
        idle_pct = idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                queue_tick();
            else
                queue_request($urandom_range(0, 3), 1'($urandom));
        end
        wait_drained();
    endtask

    // driver: one word per handshake, held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            // word taken at this edge, predict its result now
            if (req_valid && !req_stall)
                expected_status.push_back(motor_timer_step(req_word));
            // free to present the next word or to idle
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_word <= pending_words.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each taken result word, then pick the stall for next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch("unexpected word", int'(res_word), 0);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (res_word.motor_mask !== want.motor_mask)
                        report_mismatch("motor_mask", int'(res_word.motor_mask),
                                        int'(want.motor_mask));
                    if (res_word.started !== want.started)
                        report_mismatch("started", int'(res_word.started),
                                        int'(want.started));
                    if (res_word.stopped_mask !== want.stopped_mask)
                        report_mismatch("stopped_mask", int'(res_word.stopped_mask),
                                        int'(want.stopped_mask));
                end
                results_seen++;
            end
            res_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // hang detection: count cycles with work outstanding but no word moving
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
            (pending_words.size() == 0 && !req_valid && expected_status.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("timeout: no word accepted for %0d cycles", HANG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, default delays: stop of an off motor, starts, restarts
        queue_request(0, 1'b0);
        for (int d = 0; d < DRIVE_COUNT; d++)
            queue_request(d, 1'b1);
        queue_request(1, 1'b1);
        queue_request(0, 1'b0);
        // second stop while waiting does nothing
        queue_request(0, 1'b0);
        // back on from waiting, no start reported
        queue_request(0, 1'b1);
        queue_request(0, 1'b0);
        queue_request(3, 1'b0);
        // tick with every ignored field bit high
        pending_words.push_back('{mode: MODE_TICK, drive: '1, turn_on: 1'b1});
        // seven ticks run 2500 ms down past zero at 400 ms each
        repeat (6) queue_tick();
        wait_drained();

        // directed, zero delay and zero tick length: zero countdown still stops
        set_timer_config(0, 0);
        queue_request(1, 1'b0);
        queue_tick();
        queue_request(2, 1'b0);
        queue_tick();
        wait_drained();

        // random phases across the register range
        run_random_phase(0, 1, 30, 29, 100);
        run_random_phase(65535, 65535, 30, 29, 100);
        // long delay with one-ms ticks: motors sit waiting, mostly on/stop traffic
        run_random_phase(65535, 1, 20, 29, 60);
        // zero tick length with nonzero countdowns: nothing ever stops
        run_random_phase(1, 0, 30, 29, 60);
        // stretch with no idling on either side
        run_random_phase(300, 100, 30, 0, 200);
        run_random_phase(OFF_DELAY_RESET, TICK_LENGTH_RESET, 35, 29, 150);
        repeat (4)
            run_random_phase($urandom_range(0, 1500), $urandom_range(1, 600), 30, 29, 80);

        if (error_count == 0 && expected_status.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dmot_pkg.sv
rtl/dmot_in_stage.sv
rtl/dmot_core.sv
rtl/dmot_out_stage.sv
rtl/drive_motor_off_delay_timer_unit.sv
test/drive_motor_off_delay_timer_unit_test.sv
